// ----- sv/srecord_line_checker_unit_macros.svh -----
// Assertion macros used by the S-record line checker assertion file.
`ifndef SRECORD_LINE_CHECKER_UNIT_MACROS_SVH
`define SRECORD_LINE_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/slc_pkg.sv -----
// Types, constants and helpers for the S-record line checker.
`timescale 1ns / 1ps
package slc_pkg;

  localparam logic [7:0] MAX_DATA_BYTES = 8'd32;
  localparam logic [7:0] PAD_BYTE       = 8'hFF;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;

  // Record types
  localparam logic [3:0] TYPE_HEADER    = 4'd0;
  localparam logic [3:0] TYPE_DATA_LO   = 4'd1;
  localparam logic [3:0] TYPE_DATA_HI   = 4'd3;
  localparam logic [3:0] TYPE_BAD_LO    = 4'd4;
  localparam logic [3:0] TYPE_BAD_HI    = 4'd6;
  localparam logic [3:0] TYPE_END_FIRST = 4'd7;

  // Character positions within a line
  localparam logic [2:0] POS_START    = 3'd0;
  localparam logic [2:0] POS_TYPE     = 3'd1;
  localparam logic [2:0] POS_COUNT_HI = 3'd2;
  localparam logic [2:0] POS_COUNT_LO = 3'd3;
  localparam logic [2:0] POS_BYTE_HI  = 3'd4;
  localparam logic [2:0] POS_BYTE_LO  = 3'd5;

  localparam logic [4:0] BLOCK_LOG2_RESET = 5'd9;

  typedef enum logic [2:0] {
    ST_DATA_OK  = 3'd0,
    ST_HEADER   = 3'd1,
    ST_END      = 3'd2,
    ST_FORMAT   = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_e;

  typedef struct packed {
    logic [31:0] min_addr;
    logic [32:0] max_end;
    logic [31:0] sum;
    logic [31:0] count;
  } tot_t;

  localparam tot_t TOT_RESET = '{min_addr: '1, max_end: '0, sum: '0, count: '0};

  typedef struct packed {
    status_e     status;
    logic [3:0]  rtype;
    logic [31:0] addr;
    logic [5:0]  dlen;
    tot_t        tot;
  } line_res_t;

  // {valid, value} of an uppercase hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if (c >= CH_A && c <= CH_F) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

// ----- sv/slc_in_if.sv -----
// Character input channel.
`timescale 1ns / 1ps
interface slc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       new_file;

  modport source (output valid, output char_code, output new_file, input ready);
  modport sink   (input valid, input char_code, input new_file, output ready);
endinterface

// ----- sv/slc_out_if.sv -----
// Per-line result channel.
`timescale 1ns / 1ps
interface slc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  record_type;
  logic [31:0] record_address;
  logic [5:0]  data_length;
  logic [31:0] lowest_address;
  logic [32:0] highest_end;
  logic [31:0] padded_size;
  logic [31:0] byte_total;
  logic [31:0] byte_count;
  logic [31:0] padded_total;

  modport source (
    output valid, output status, output record_type, output record_address,
    output data_length, output lowest_address, output highest_end,
    output padded_size, output byte_total, output byte_count, output padded_total,
    input ready
  );
  modport sink (
    input valid, input status, input record_type, input record_address,
    input data_length, input lowest_address, input highest_end,
    input padded_size, input byte_total, input byte_count, input padded_total,
    output ready
  );
endinterface

// ----- sv/slc_line_parser.sv -----
// Per-character line state and running file totals.
`timescale 1ns / 1ps
module slc_line_parser
  import slc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] char_i,
  input  logic       new_file_i,
  output line_res_t  res_o,
  output tot_t       tot_o,
  output logic       tot_chg_o
);

  logic [2:0]  ci_q, ci_d;
  logic [3:0]  type_q, type_d;
  logic [3:0]  nib_q, nib_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [31:0] addr_q, addr_d;
  logic [7:0]  lsum_q, lsum_d;
  logic [7:0]  left_q, left_d;
  logic        err_q, err_d;
  logic [7:0]  cks_q, cks_d;
  tot_t        tot_q, tot_d;

  tot_t        tot_eff;
  line_res_t   res;
  logic [7:0]  dlen_w;
  logic [32:0] end_w;

  // line end evaluation
  always_comb begin
    tot_eff    = new_file_i ? TOT_RESET : tot_q;
    dlen_w     = cnt_q - {4'd0, type_q} - 8'd2;
    end_w      = {1'b0, addr_q} + {25'd0, dlen_w};
    res        = '0;
    res.status = ST_FORMAT;
    res.rtype  = type_q;
    res.tot    = tot_eff;
    if (err_q || ci_q < POS_COUNT_HI) begin
      res.status = ST_FORMAT;
    end else if (type_q == TYPE_HEADER) begin
      res.status = ST_HEADER;
    end else if (type_q >= TYPE_END_FIRST) begin
      res.status = ST_END;
    end else if (ci_q != POS_BYTE_HI || left_q != 8'd0) begin
      res.status = ST_FORMAT;
    end else begin
      res.dlen = dlen_w[5:0];
      res.addr = addr_q;
      if (addr_q < tot_eff.min_addr) begin
        res.tot.min_addr = addr_q;
      end
      if (end_w > tot_eff.max_end) begin
        res.tot.max_end = end_w;
      end
      res.status = ((~lsum_q) == cks_q) ? ST_DATA_OK : ST_CHECKSUM;
    end
  end

  // character handling
  always_comb begin
    logic [4:0] hv;
    logic [7:0] b;
    logic [7:0] need;
    logic [7:0] used;
    logic       is_skip;

    hv      = hex_value(char_i);
    b       = {nib_q, hv[3:0]};
    need    = {4'd0, type_q} + 8'd2;
    used    = cnt_q - left_q;
    is_skip = (char_i == CH_LF) || (char_i == CH_TAB) || (char_i == CH_SPACE);

    ci_d   = ci_q;
    type_d = type_q;
    nib_d  = nib_q;
    cnt_d  = cnt_q;
    addr_d = addr_q;
    lsum_d = lsum_q;
    left_d = left_q;
    err_d  = err_q;
    cks_d  = cks_q;
    tot_d  = tot_q;

    if (step_i) begin
      tot_d = tot_eff;
      if (char_i == CH_CR) begin
        tot_d  = res.tot;
        ci_d   = POS_START;
        type_d = TYPE_HEADER;
        nib_d  = '0;
        cnt_d  = '0;
        addr_d = '0;
        lsum_d = '0;
        left_d = '0;
        err_d  = 1'b0;
        cks_d  = '0;
      end else if (!is_skip) begin
        ci_d = (ci_q < POS_BYTE_LO) ? ci_q + 3'd1 : POS_BYTE_HI;
        if (ci_q == POS_START) begin
          if (char_i != CH_S) begin
            err_d = 1'b1;
          end
        end else if (ci_q == POS_TYPE) begin
          if (char_i >= CH_0 && char_i <= CH_9) begin
            type_d = char_i[3:0];
            if (char_i[3:0] >= TYPE_BAD_LO && char_i[3:0] <= TYPE_BAD_HI) begin
              err_d = 1'b1;
            end
          end else begin
            type_d = TYPE_HEADER;
            err_d  = 1'b1;
          end
        end else if (type_q >= TYPE_DATA_LO && type_q <= TYPE_DATA_HI && !err_q) begin
          if (!hv[4]) begin
            err_d = 1'b1;
          end else if (ci_q == POS_COUNT_HI || ci_q == POS_BYTE_HI) begin
            nib_d = hv[3:0];
          end else if (ci_q == POS_COUNT_LO) begin
            cnt_d  = b;
            lsum_d = b;
            left_d = b;
            if (b < need || (b - need) > MAX_DATA_BYTES) begin
              err_d = 1'b1;
            end
          end else if (left_q == 8'd0) begin
            err_d = 1'b1;
          end else begin
            left_d = left_q - 8'd1;
            if (used < ({4'd0, type_q} + 8'd1)) begin
              addr_d = {addr_q[23:0], b};
              lsum_d = lsum_q + b;
            end else if (left_q == 8'd1) begin
              cks_d = b;
            end else begin
              lsum_d      = lsum_q + b;
              tot_d.sum   = tot_eff.sum + {24'd0, b};
              tot_d.count = tot_eff.count + 32'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q   <= POS_START;
      type_q <= TYPE_HEADER;
      nib_q  <= '0;
      cnt_q  <= '0;
      addr_q <= '0;
      lsum_q <= '0;
      left_q <= '0;
      err_q  <= 1'b0;
      cks_q  <= '0;
      tot_q  <= TOT_RESET;
    end else begin
      ci_q   <= ci_d;
      type_q <= type_d;
      nib_q  <= nib_d;
      cnt_q  <= cnt_d;
      addr_q <= addr_d;
      lsum_q <= lsum_d;
      left_q <= left_d;
      err_q  <= err_d;
      cks_q  <= cks_d;
      tot_q  <= tot_d;
    end
  end

  assign res_o     = res;
  assign tot_o     = tot_q;
  assign tot_chg_o = (tot_d != tot_q);

endmodule

// ----- sv/slc_pad_calc.sv -----
// Pipelined padded span and padded byte total from the running totals.
`timescale 1ns / 1ps
module slc_pad_calc
  import slc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tot_t        tot_i,
  input  logic [4:0]  block_log2_i,
  input  logic        chg_i,
  output logic [31:0] psize_o,
  output logic [31:0] ptotal_o,
  output logic        ready_o
);

  logic [32:0] span_q, span_d;
  logic [31:0] psize_q, psize_d;
  logic [31:0] diff_q, diff_d;
  logic [31:0] ptotal_q, ptotal_d;
  logic [3:0]  vld_q, vld_d;

  always_comb begin
    logic [34:0] mask;
    logic [34:0] rnd;

    span_d   = (tot_i.max_end > {1'b0, tot_i.min_addr})
             ? tot_i.max_end - {1'b0, tot_i.min_addr} : 33'd0;
    mask     = (35'd1 << block_log2_i) - 35'd1;
    rnd      = ({2'b00, span_q} + mask) & ~mask;
    psize_d  = (rnd[34:32] != 3'd0) ? '1 : rnd[31:0];
    diff_d   = psize_q - tot_i.count;
    // 0xFF * diff + sum, as (diff << 8) - diff + sum
    ptotal_d = {diff_q[23:0], 8'd0} - diff_q + tot_i.sum;
    // a stage is good once it saw the same totals for its whole chain
    vld_d    = chg_i ? 4'd0 : {vld_q[2:0], 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q   <= span_d;
    psize_q  <= psize_d;
    diff_q   <= diff_d;
    ptotal_q <= ptotal_d;
  end

  assign psize_o  = psize_q;
  assign ptotal_o = ptotal_q;
  assign ready_o  = vld_q[3];

endmodule

// ----- sv/srecord_line_checker_unit.sv -----
// Top level of the S-record line checker.
`timescale 1ns / 1ps
// S-record line checker. Takes one text character per beat on in_i and
// gives one result beat on out_o for every CR: the line status, its type,
// address and data length, and the file's running totals. LF, tab and
// space are dropped, new_file clears the totals before its character is
// handled. A character passes an input register and is handled from
// there, so one character is taken per clock while no CR is waiting; a
// result sits in an output register while further characters of the next
// line keep flowing. A CR waits while the output register is still full.
// The padded size and padded total of an end record come from a
// four-stage pipeline that follows the totals; an end-record CR without
// new_file that reaches the block before that pipeline has settled after
// a totals change or a block size write is held while the pipeline
// catches up. block_size_log2 is written through cfg_we_i / cfg_wdata_i
// (reset value 9).
module srecord_line_checker_unit
  import slc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  slc_in_if.sink     in_i,
  slc_out_if.source  out_o
);

  // configuration
  logic [4:0] blk_log2_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_nf_q;

  // output register
  logic        out_valid_q, out_valid_d;
  line_res_t   out_res_q;
  logic [31:0] out_psize_q;
  logic [31:0] out_ptotal_q;

  line_res_t   line_res;
  tot_t        tot;
  logic        tot_chg;
  logic [31:0] pad_psize;
  logic [31:0] pad_ptotal;
  logic        pad_ready;

  logic is_cr;
  logic is_end;
  logic out_free;
  logic take;

  slc_line_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (take),
    .char_i     (in_char_q),
    .new_file_i (in_nf_q),
    .res_o      (line_res),
    .tot_o      (tot),
    .tot_chg_o  (tot_chg)
  );

  slc_pad_calc u_pad (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tot_i        (tot),
    .block_log2_i (blk_log2_q),
    .chg_i        (tot_chg || cfg_we_i),
    .psize_o      (pad_psize),
    .ptotal_o     (pad_ptotal),
    .ready_o      (pad_ready)
  );

  always_comb begin
    is_cr    = (in_char_q == CH_CR);
    is_end   = (line_res.status == ST_END);
    out_free = !out_valid_q || out_o.ready;
    // new_file on the end record itself empties the totals: span is zero,
    // no need to wait for the pad pipeline
    take     = in_valid_q &&
               (!is_cr || (out_free && (!is_end || in_nf_q || pad_ready)));
    out_valid_d = (take && is_cr) ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  assign in_i.ready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_log2_q  <= BLOCK_LOG2_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blk_log2_q <= cfg_wdata_i;
      end
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.char_code;
      in_nf_q   <= in_i.new_file;
    end
    if (take && is_cr) begin
      out_res_q <= line_res;
      if (is_end && !in_nf_q) begin
        out_psize_q  <= pad_psize;
        out_ptotal_q <= pad_ptotal;
      end else begin
        out_psize_q  <= '0;
        out_ptotal_q <= '0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_res_q.status;
  assign out_o.record_type    = out_res_q.rtype;
  assign out_o.record_address = out_res_q.addr;
  assign out_o.data_length    = out_res_q.dlen;
  assign out_o.lowest_address = out_res_q.tot.min_addr;
  assign out_o.highest_end    = out_res_q.tot.max_end;
  assign out_o.padded_size    = out_psize_q;
  assign out_o.byte_total     = out_res_q.tot.sum;
  assign out_o.byte_count     = out_res_q.tot.count;
  assign out_o.padded_total   = out_ptotal_q;

endmodule

// ----- sv/slc_checker.sv -----
// Port-level assertions for the S-record line checker, bound to the top level.
`timescale 1ns / 1ps
`include "srecord_line_checker_unit_macros.svh"
module slc_checker
  import slc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_record_address,
  input logic [5:0]  out_data_length,
  input logic [31:0] out_padded_size,
  input logic [31:0] out_padded_total
);

  // a stalled result beat holds
  `SLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_record_address), "result beat changed while stalled")

  // padded figures only on end records
  `SLC_ASSERT_IMP(a_pad_end_only, clk_i, rst_ni, out_valid && (out_status != ST_END), (out_padded_size == 32'd0) && (out_padded_total == 32'd0), "padded figures outside end record")

  // address and length only on parsed data lines
  `SLC_ASSERT_IMP(a_addr_data_only, clk_i, rst_ni, out_valid && (out_status != ST_DATA_OK) && (out_status != ST_CHECKSUM), (out_record_address == 32'd0) && (out_data_length == 6'd0), "address or length on non-data line")

  // data length never exceeds the line limit
  `SLC_ASSERT_IMP(a_len_limit, clk_i, rst_ni, out_valid, {2'b00, out_data_length} <= MAX_DATA_BYTES, "data length above limit")

endmodule

bind srecord_line_checker_unit slc_checker u_slc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid          (out_o.valid),
  .out_ready          (out_o.ready),
  .out_status         (out_o.status),
  .out_record_address (out_o.record_address),
  .out_data_length    (out_o.data_length),
  .out_padded_size    (out_o.padded_size),
  .out_padded_total   (out_o.padded_total)
);
